/* rtl/core/shape_compactness_tracker_core_assert.svh */
// Assertion macros shared by the core. Each one samples on clk and is
// disabled while rst is high.
`ifndef SHAPE_COMPACTNESS_TRACKER_CORE_ASSERT_SVH
`define SHAPE_COMPACTNESS_TRACKER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shape compactness tracker assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shape compactness tracker assertion failed");

`endif

/* rtl/core/sct_pkg.sv */
package sct_pkg;

  // Field widths.
  localparam int unsigned DataW  = 16;
  localparam int unsigned ResW   = 32;
  localparam int unsigned DblW   = DataW + 1;
  localparam int unsigned SqW    = 2 * DblW;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned PDataW = 32;

  // One quotient bit per division step.
  localparam int unsigned DivSteps  = SqW;
  localparam int unsigned DivCountW = $clog2(DivSteps + 1);

  // Register reset values.
  localparam logic [DataW-1:0] StepMinReset  = 16'd90;
  localparam logic [DataW-1:0] GrowMinUReset = 16'd700;
  localparam logic [DataW-1:0] GrowMinVReset = 16'd500;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_CENTRE_U   = 3'd0,
    REG_CENTRE_V   = 3'd1,
    REG_STEP_MIN   = 3'd2,
    REG_GROW_MIN_U = 3'd3,
    REG_GROW_MIN_V = 3'd4
  } reg_index_t;

  // Program counter and step addresses of the microprogram.
  localparam int unsigned PcW = 3;
  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PcWait    = 3'd0;
  localparam pc_t PcPerim   = 3'd1;
  localparam pc_t PcDiam    = 3'd2;
  localparam pc_t PcSquare  = 3'd3;
  localparam pc_t PcDivide  = 3'd4;
  localparam pc_t PcFinish  = 3'd5;
  localparam pc_t PcRestart = 3'd6;

  // Jump conditions. When the condition holds the sequencer goes to the
  // target, otherwise it falls through to the next step.
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_INPUT = 3'd2,
    C_DIV_MORE = 3'd3,
    C_OUT_BUSY = 3'd4
  } cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  take_in;
    logic  upd_perim;
    logic  upd_diam;
    logic  load_square;
    logic  div_step;
    logic  load_out;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Microprogram read-only table.
  function automatic ctrl_t ctrl_rom(input pc_t pc);
    ctrl_t w;
    w = '{take_in: 1'b0, upd_perim: 1'b0, upd_diam: 1'b0, load_square: 1'b0,
          div_step: 1'b0, load_out: 1'b0, cond: C_ALWAYS, target: PcWait};
    case (pc)
      PcWait: begin
        w.take_in = 1'b1;
        w.cond    = C_NO_INPUT;
        w.target  = PcWait;
      end
      PcPerim: begin
        w.upd_perim = 1'b1;
        w.cond      = C_NEVER;
      end
      PcDiam: begin
        w.upd_diam = 1'b1;
        w.cond     = C_NEVER;
      end
      PcSquare: begin
        w.load_square = 1'b1;
        w.cond        = C_NEVER;
      end
      PcDivide: begin
        w.div_step = 1'b1;
        w.cond     = C_DIV_MORE;
        w.target   = PcDivide;
      end
      PcFinish: begin
        w.load_out = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.target   = PcFinish;
      end
      PcRestart: begin
        w.cond   = C_ALWAYS;
        w.target = PcWait;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = PcWait;
      end
    endcase
    return w;
  endfunction

  // Absolute difference of two unsigned values.
  function automatic logic [DataW-1:0] abs_diff(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    logic [DataW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

/* rtl/core/shape_compactness_tracker_core.sv */
// Shape compactness tracker. Each input transfer carries a step reference
// and a two-axis sample; each one yields exactly one result transfer with
// (2*perimeter)^2 / (diameter+1), saturated to all ones, plus the current
// perimeter and diameter sums and a range error flag. A short microprogram
// steps a plain datapath in order: take the transfer, update the perimeter,
// update the diameter, do the 17-by-17 squaring, run the restoring divider
// that retires one quotient bit per cycle, load the output register and
// return; a new item is taken only once the sequencer is back at the wait
// step. If the previous result is still held in the output register, the
// sequencer waits at the output load step until it is taken. Configuration
// registers sit on an APB-style port at byte addresses 0, 4, 8, 12 and 16
// and should be written only while the block is idle.
module shape_compactness_tracker_core
  import sct_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [PDataW-1:0]   pwdata,
  output logic [PDataW-1:0]   prdata,
  output logic                pready,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DataW-1:0]    step_ref,
  input  logic [DataW-1:0]    sample_u,
  input  logic [DataW-1:0]    sample_v,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [ResW-1:0]     compactness,
  output logic [DataW-1:0]    perimeter_total,
  output logic [DataW-1:0]    diameter_total,
  output logic                range_error
);

  // Configuration registers.
  logic [DataW-1:0] centre_u;
  logic [DataW-1:0] centre_v;
  logic [DataW-1:0] step_min;
  logic [DataW-1:0] grow_min_u;
  logic [DataW-1:0] grow_min_v;

  // Tracking state.
  logic [DataW-1:0] max_dist_u;
  logic [DataW-1:0] max_dist_v;
  logic [DataW-1:0] diameter_sum;
  logic [DataW-1:0] perimeter_sum;

  // Latched input fields.
  logic [DataW-1:0] ref_l;
  logic [DataW-1:0] su_l;
  logic [DataW-1:0] sv_l;

  // Divider registers.
  logic [SqW-1:0]       dq;
  logic [DataW-1:0]     rem;
  logic [DataW-1:0]     divisor;
  logic                 div_zero;
  logic [DivCountW-1:0] div_count;

  // Sequencer.
  pc_t   pc;
  pc_t   pc_next;
  ctrl_t word;
  logic  cond_hit;
  logic  in_fire;
  logic  out_busy;

  reg_index_t cfg_index;
  logic       cfg_write;

  // Datapath combinational values.
  logic [DataW-1:0] step_len;
  logic [DataW-1:0] du;
  logic [DataW-1:0] dv;
  logic [DataW-1:0] cand_u;
  logic [DataW-1:0] cand_v;
  logic [DataW-1:0] grow_u;
  logic [DataW-1:0] grow_v;
  logic [DblW-1:0]  dbl;
  logic [DataW:0]   rem_shift;
  logic             q_bit;
  logic             saturate;

  // Configuration port: pready stays high, writes land in the access cycle.
  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_u   <= '0;
      centre_v   <= '0;
      step_min   <= StepMinReset;
      grow_min_u <= GrowMinUReset;
      grow_min_v <= GrowMinVReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTRE_U:   centre_u   <= pwdata[DataW-1:0];
        REG_CENTRE_V:   centre_v   <= pwdata[DataW-1:0];
        REG_STEP_MIN:   step_min   <= pwdata[DataW-1:0];
        REG_GROW_MIN_U: grow_min_u <= pwdata[DataW-1:0];
        REG_GROW_MIN_V: grow_min_v <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back, zero beyond the list.
  always_comb begin
    case (cfg_index)
      REG_CENTRE_U:   prdata = {{(PDataW-DataW){1'b0}}, centre_u};
      REG_CENTRE_V:   prdata = {{(PDataW-DataW){1'b0}}, centre_v};
      REG_STEP_MIN:   prdata = {{(PDataW-DataW){1'b0}}, step_min};
      REG_GROW_MIN_U: prdata = {{(PDataW-DataW){1'b0}}, grow_min_u};
      REG_GROW_MIN_V: prdata = {{(PDataW-DataW){1'b0}}, grow_min_v};
      default:        prdata = '0;
    endcase
  end

  // Control word fetch and jump condition.
  assign word     = ctrl_rom(pc);
  assign in_ready = word.take_in;
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    case (word.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_INPUT: cond_hit = !in_valid;
      C_DIV_MORE: cond_hit = (div_count != DivCountW'(1));
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? word.target : pc + pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PcWait;
    end else begin
      pc <= pc_next;
    end
  end

  // Input latch on transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ref_l <= step_ref;
      su_l  <= sample_u;
      sv_l  <= sample_v;
    end
  end

  // Perimeter and diameter candidates from the latched sample.
  always_comb begin
    step_len = abs_diff(ref_l, sv_l);
    du       = abs_diff(centre_u, su_l);
    dv       = abs_diff(centre_v, sv_l);
    cand_u   = (du > max_dist_u) ? du : max_dist_u;
    cand_v   = (dv > max_dist_v) ? dv : max_dist_v;
    grow_u   = cand_u - max_dist_u;
    grow_v   = cand_v - max_dist_v;
  end

  // Tracking state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      perimeter_sum <= '0;
      max_dist_u    <= '0;
      max_dist_v    <= '0;
      diameter_sum  <= '0;
    end else begin
      if (word.upd_perim && (step_len > step_min)) begin
        perimeter_sum <= perimeter_sum + step_len;
      end
      if (word.upd_diam && ((grow_u > grow_min_u) || (grow_v > grow_min_v))) begin
        max_dist_u   <= cand_u;
        max_dist_v   <= cand_v;
        diameter_sum <= cand_u + cand_v;
      end
    end
  end

  // Restoring division step: shift in one dividend bit, subtract if it fits.
  assign dbl       = {perimeter_sum, 1'b0};
  assign rem_shift = {rem, dq[SqW-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (word.load_square) begin
      div_count <= DivCountW'(DivSteps);
    end else if (word.div_step) begin
      div_count <= div_count - DivCountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (word.load_square) begin
      dq       <= dbl * dbl;
      rem      <= '0;
      divisor  <= diameter_sum + DataW'(1);
      div_zero <= (diameter_sum == '1);
    end else if (word.div_step) begin
      dq  <= {dq[SqW-2:0], q_bit};
      rem <= q_bit ? DataW'(rem_shift - {1'b0, divisor}) : rem_shift[DataW-1:0];
    end
  end

  // Output register: loaded once the previous result has been taken.
  assign saturate = div_zero || (dq[SqW-1:ResW] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word.load_out && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word.load_out && !out_busy) begin
      compactness     <= saturate ? '1 : dq[ResW-1:0];
      perimeter_total <= perimeter_sum;
      diameter_total  <= diameter_sum;
      range_error     <= saturate;
    end
  end

`include "shape_compactness_tracker_core_assert.svh"

  // An accepted item always moves on to the perimeter step.
  `SCT_ASSERT_NEXT(a_accept_advances, in_fire, pc == PcPerim)

  // The divider never runs with an exhausted step count.
  `SCT_ASSERT_NOW(a_div_count_live, pc == PcDivide, div_count != '0)

  // The axis maxima and diameter only change in the diameter step.
  `SCT_ASSERT_NEXT(a_max_u_stable, pc != PcDiam, $stable(max_dist_u))
  `SCT_ASSERT_NEXT(a_max_v_stable, pc != PcDiam, $stable(max_dist_v))
  `SCT_ASSERT_NEXT(a_diam_stable, pc != PcDiam, $stable(diameter_sum))

  // A flagged result always carries the saturated value.
  `SCT_ASSERT_NOW(a_error_saturates, out_valid && range_error, compactness == '1)

endmodule

/* test/sct_result_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both data channels, keeps its own copy of
// the tracked shape, and compares every result transfer with the oldest
// predicted one.
module sct_result_checker
  import sct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [AddrW-1:0]  paddr,
  input  logic [PDataW-1:0] pwdata,

  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [DataW-1:0]  step_ref,
  input  logic [DataW-1:0]  sample_u,
  input  logic [DataW-1:0]  sample_v,

  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ResW-1:0]   compactness,
  input  logic [DataW-1:0]  perimeter_total,
  input  logic [DataW-1:0]  diameter_total,
  input  logic              range_error,

  output int                mismatch_count,
  output int                shapes_waiting
);

  typedef struct packed {
    logic [ResW-1:0]  compactness;
    logic [DataW-1:0] perimeter;
    logic [DataW-1:0] diameter;
    logic             range_error;
  } shape_result_t;

  localparam logic [ResW-1:0] CompSaturated = '1;
  localparam int MaxReported = 10;

  // Shadow copy of the configuration registers.
  logic [DataW-1:0] centre_u_q;
  logic [DataW-1:0] centre_v_q;
  logic [DataW-1:0] step_min_q;
  logic [DataW-1:0] grow_min_u_q;
  logic [DataW-1:0] grow_min_v_q;

  // Tracked shape: per-axis reach from the centre and the two running sums.
  logic [DataW-1:0] reach_u;
  logic [DataW-1:0] reach_v;
  logic [DataW-1:0] diam_q;
  logic [DataW-1:0] perim_q;

  shape_result_t expected_shapes[$];
  int fails;

  function automatic logic [DataW-1:0] distance(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Folds one sample into the tracked shape and works out the result it gives.
  function automatic shape_result_t advance_shape(input logic [DataW-1:0] step_in,
                                                  input logic [DataW-1:0] su,
                                                  input logic [DataW-1:0] sv);
    logic [DataW-1:0] step_len;
    logic [DataW-1:0] cand_u;
    logic [DataW-1:0] cand_v;
    logic [DataW-1:0] growth_u;
    logic [DataW-1:0] growth_v;
    logic [DataW-1:0] divisor;
    logic [DblW-1:0]  doubled;
    logic [63:0]      square;
    logic [63:0]      quotient;
    shape_result_t    r;

    // A long enough step extends the perimeter, wrapping at 16 bits.
    step_len = distance(step_in, sv);
    if (step_len > step_min_q) begin
      perim_q = perim_q + step_len;
    end

    // Both reaches are taken over together once either one grows enough.
    cand_u = (distance(centre_u_q, su) > reach_u) ? distance(centre_u_q, su) : reach_u;
    cand_v = (distance(centre_v_q, sv) > reach_v) ? distance(centre_v_q, sv) : reach_v;
    growth_u = cand_u - reach_u;
    growth_v = cand_v - reach_v;
    if (growth_u > grow_min_u_q || growth_v > grow_min_v_q) begin
      reach_u = cand_u;
      reach_v = cand_v;
      diam_q  = reach_u + reach_v;
    end

    // Squared doubled perimeter over the 16-bit divisor, saturating.
    divisor  = diam_q + 16'd1;
    doubled  = {perim_q, 1'b0};
    square   = 64'(doubled) * 64'(doubled);
    r.perimeter = perim_q;
    r.diameter  = diam_q;
    if (divisor == '0) begin
      r.compactness = CompSaturated;
      r.range_error = 1'b1;
    end else begin
      quotient = square / 64'(divisor);
      if (quotient > 64'(CompSaturated)) begin
        r.compactness = CompSaturated;
        r.range_error = 1'b1;
      end else begin
        r.compactness = quotient[ResW-1:0];
        r.range_error = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    shape_result_t got;
    shape_result_t want;
    if (rst) begin
      centre_u_q   = '0;
      centre_v_q   = '0;
      step_min_q   = StepMinReset;
      grow_min_u_q = GrowMinUReset;
      grow_min_v_q = GrowMinVReset;
      reach_u      = '0;
      reach_v      = '0;
      diam_q       = '0;
      perim_q      = '0;
      fails        = 0;
      expected_shapes.delete();
      mismatch_count <= 0;
      shapes_waiting <= 0;
    end else begin
      // Register writes; indexes past the list are ignored.
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[AddrW-1:2]))
          REG_CENTRE_U:   centre_u_q   = pwdata[DataW-1:0];
          REG_CENTRE_V:   centre_v_q   = pwdata[DataW-1:0];
          REG_STEP_MIN:   step_min_q   = pwdata[DataW-1:0];
          REG_GROW_MIN_U: grow_min_u_q = pwdata[DataW-1:0];
          REG_GROW_MIN_V: grow_min_v_q = pwdata[DataW-1:0];
          default: begin
          end
        endcase
      end

      // Result transfers are matched before this edge's input is predicted.
      if (out_valid && out_ready) begin
        got = '{compactness, perimeter_total, diameter_total, range_error};
        if (expected_shapes.size() == 0) begin
          if (fails < MaxReported) begin
            $display("unexpected result: comp=%h perim=%h diam=%h err=%b",
                     got.compactness, got.perimeter, got.diameter, got.range_error);
          end
          fails++;
        end else begin
          want = expected_shapes.pop_front();
          if (got.compactness !== want.compactness || got.perimeter !== want.perimeter ||
              got.diameter !== want.diameter || got.range_error !== want.range_error) begin
            if (fails < MaxReported) begin
              $display("result differs: comp=%h/%h perim=%h/%h diam=%h/%h err=%b/%b",
                       want.compactness, got.compactness, want.perimeter, got.perimeter,
                       want.diameter, got.diameter, want.range_error, got.range_error);
            end
            fails++;
          end
        end
      end

      if (in_valid && in_ready) begin
        expected_shapes.push_back(advance_shape(step_ref, sample_u, sample_v));
      end

      mismatch_count <= fails;
      shapes_waiting <= expected_shapes.size();
    end
  end

endmodule

/* test/shape_compactness_tracker_core_tb.sv */
`timescale 1ns / 1ps

module shape_compactness_tracker_core_tb;
  import sct_pkg::*;

  localparam int IdleLimit      = 5000;
  localparam int TailCycles     = 200;
  localparam int PressureCycles = 800;
  localparam int RandomPhases   = 8;
  localparam int PhaseItems     = 135;
  localparam int FieldTop       = 65535;
  localparam int FrontierStart  = 33000;
  localparam logic [2:0] FirstUnusedReg = 3'd5;
  localparam logic [2:0] LastUnusedReg  = 3'd7;
  localparam logic [DataW-1:0] FieldMax = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [PDataW-1:0] pwdata = '0;
  logic [PDataW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DataW-1:0]  step_ref = '0;
  logic [DataW-1:0]  sample_u = '0;
  logic [DataW-1:0]  sample_v = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ResW-1:0]   compactness;
  logic [DataW-1:0]  perimeter_total;
  logic [DataW-1:0]  diameter_total;
  logic              range_error;
  int                mismatch_count;
  int                shapes_waiting;
  bit                pressure_go = 1'b0;

  shape_compactness_tracker_core uut (.*);

  sct_result_checker result_check (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 5);
    if (r < 97) return $urandom_range(6, 40);
    return $urandom_range(100, 300);
  endfunction

  // Offers one sample and returns at the edge where it is transferred.
  task automatic send_item(input logic [DataW-1:0] s_ref, input logic [DataW-1:0] su,
                           input logic [DataW-1:0] sv);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    step_ref <= s_ref;
    sample_u <= su;
    sample_v <= sv;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (shapes_waiting != 0);
  endtask

  // One register write: setup cycle, then access until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Register values for a random phase, with the extremes mixed in.
  function automatic logic [DataW-1:0] phase_value(input reg_index_t idx);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return FieldMax;
    case (idx)
      REG_CENTRE_U, REG_CENTRE_V: return 16'($urandom);
      REG_STEP_MIN:               return 16'($urandom_range(0, 3000));
      default:                    return 16'($urandom_range(0, 2000));
    endcase
  endfunction

  // Distance from the centre: mostly just under a slowly rising frontier,
  // so that the running maxima keep growing in small steps.
  function automatic int pick_dist(input int frontier);
    int d;
    if ($urandom_range(0, 99) < 95) begin
      d = frontier - int'($urandom_range(0, 1500));
      if (d < 0) d = 0;
    end else begin
      d = $urandom_range(0, frontier);
    end
    return d;
  endfunction

  // Puts a sample at the given distance on either side of the centre.
  function automatic logic [DataW-1:0] place(input logic [DataW-1:0] centre, input int d);
    int c;
    c = centre;
    if (c >= d && (c + d > FieldTop || $urandom_range(0, 1) == 1)) return 16'(c - d);
    if (c + d <= FieldTop) return 16'(c + d);
    return (c >= 32768) ? '0 : FieldMax;
  endfunction

  // Value near the given one, clipped to the field's range.
  function automatic logic [DataW-1:0] near(input logic [DataW-1:0] base, input int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > FieldTop) v = FieldTop;
    return 16'(v);
  endfunction

  // Result side: segments of ready and of stall, plus one long hold-off.
  initial begin : result_side
    int   seg_left;
    logic seg_ready;
    bit   pressure_done;
    seg_left      = 0;
    seg_ready     = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        if (pressure_go && !pressure_done) begin
          seg_ready     = 1'b0;
          seg_left      = PressureCycles;
          pressure_done = 1'b1;
        end else if (seg_ready) begin
          seg_left  = gap_len();
          seg_ready = 1'b0;
          if (seg_left == 0) begin
            seg_ready = 1'b1;
            seg_left  = $urandom_range(1, 60);
          end
        end else begin
          seg_ready = 1'b1;
          seg_left  = $urandom_range(1, 60);
        end
      end
      seg_left--;
      out_ready <= seg_ready;
    end
  end

  // Ends the run when nothing has been transferred for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("shape_compactness_tracker_core: mismatch");
    $finish;
  end

  // Stimulus: directed items at reset and extreme settings, then random phases.
  initial begin : stimulus
    logic [DataW-1:0] cu;
    logic [DataW-1:0] cv;
    logic [DataW-1:0] smin;
    logic [DataW-1:0] su;
    logic [DataW-1:0] sv;
    logic [DataW-1:0] sref;
    int frontier;
    int done_items;
    done_items = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: thresholds met exactly, saturation, wrapping sums,
    // and a diameter of all ones so that the divisor wraps to zero.
    send_item(16'd0, 16'd0, 16'd0);
    send_item(16'd90, 16'd0, 16'd0);
    send_item(16'd91, 16'd0, 16'd0);
    send_item(16'd0, 16'd700, 16'd0);
    send_item(16'd0, 16'd0, 16'd500);
    send_item(16'd40000, 16'd0, 16'd0);
    send_item(FieldMax, 16'd0, 16'd0);
    send_item(16'd0, 16'd32768, 16'd32767);
    send_item(16'hAAAA, 16'h5555, 16'h5555);
    send_item(16'h5555, 16'h2AAA, 16'h2AAA);
    settle();

    // All registers at their top value; nothing can grow. Writes past the
    // register list must leave the settings alone.
    write_reg(REG_CENTRE_U, FieldMax);
    write_reg(REG_CENTRE_V, FieldMax);
    write_reg(REG_STEP_MIN, FieldMax);
    write_reg(REG_GROW_MIN_U, FieldMax);
    write_reg(REG_GROW_MIN_V, FieldMax);
    write_reg(FirstUnusedReg, 16'd0);
    write_reg(LastUnusedReg, 16'd0);
    send_item(FieldMax, 16'd0, 16'd0);
    send_item(16'd0, 16'd0, FieldMax);
    send_item(FieldMax, FieldMax, FieldMax);
    settle();

    // All registers at zero.
    write_reg(REG_CENTRE_U, 16'd0);
    write_reg(REG_CENTRE_V, 16'd0);
    write_reg(REG_STEP_MIN, 16'd0);
    write_reg(REG_GROW_MIN_U, 16'd0);
    write_reg(REG_GROW_MIN_V, 16'd0);
    send_item(16'd1, 16'd0, 16'd0);
    send_item(16'd0, 16'd0, 16'd0);
    send_item(16'd5, 16'd100, 16'd5);
    settle();

    // Random phases, each with its own settings.
    for (int p = 0; p < RandomPhases; p++) begin
      cu   = phase_value(REG_CENTRE_U);
      cv   = phase_value(REG_CENTRE_V);
      smin = phase_value(REG_STEP_MIN);
      write_reg(REG_CENTRE_U, cu);
      write_reg(REG_CENTRE_V, cv);
      write_reg(REG_STEP_MIN, smin);
      write_reg(REG_GROW_MIN_U, phase_value(REG_GROW_MIN_U));
      write_reg(REG_GROW_MIN_V, phase_value(REG_GROW_MIN_V));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(3'($urandom_range(FirstUnusedReg, LastUnusedReg)), 16'($urandom));
      end
      pressure_go = 1'b1;

      for (int k = 0; k < PhaseItems; k++) begin
        frontier = FrontierStart +
                   (done_items * (FieldTop - FrontierStart)) / (RandomPhases * PhaseItems);
        su = place(cu, pick_dist(frontier));
        sv = place(cv, pick_dist(frontier));
        if ($urandom_range(0, 99) < 60) begin
          sref = 16'($urandom);
        end else begin
          sref = near(sv, int'(smin) + 8);
        end
        send_item(sref, su, sv);
        done_items++;
      end
      settle();
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("shape_compactness_tracker_core: match");
    end else begin
      $display("shape_compactness_tracker_core: mismatch");
    end
    $finish;
  end

endmodule
